// ----- hw/rtl/mm3_pkg.sv -----
// Shared constants, command codes and interface types for the MurmurHash3 stream hasher.
package mm3_pkg;

  localparam logic [31:0] C1 = 32'hcc9e2d51;
  localparam logic [31:0] C2 = 32'h1b873593;
  localparam logic [31:0] MixAdd = 32'he6546b64;
  localparam logic [31:0] F1 = 32'h85ebca6b;
  localparam logic [31:0] F2 = 32'hc2b2ae35;

  localparam int unsigned OpW = 3;
  localparam logic [OpW-1:0] OP_NONE   = 3'd0;
  localparam logic [OpW-1:0] OP_ABSORB = 3'd1;
  localparam logic [OpW-1:0] OP_SCR1   = 3'd2;
  localparam logic [OpW-1:0] OP_SCR2   = 3'd3;
  localparam logic [OpW-1:0] OP_MIX    = 3'd4;
  localparam logic [OpW-1:0] OP_FIN1   = 3'd5;
  localparam logic [OpW-1:0] OP_FIN2   = 3'd6;
  localparam logic [OpW-1:0] OP_FIN3   = 3'd7;

  typedef struct packed {
    logic [OpW-1:0] op;
  } cmd_t;

  typedef struct packed {
    logic cnt_full;
    logic out_free;
  } sts_t;

endpackage

// ----- hw/rtl/mm3_datapath.sv -----
// Datapath: seed, running hash, byte packing, shared multiplier and result register.
module mm3_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [31:0]       cfg_data_i,
  input  logic [7:0]        data_byte_i,
  input  logic              byte_present_i,
  input  logic              last_i,
  input  mm3_pkg::cmd_t     cmd_i,
  output mm3_pkg::sts_t     sts_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [31:0]       hash_value_o
);

  logic [31:0] seed_q, seed_d;
  logic [31:0] hash_q, hash_d;
  logic [31:0] k_q, k_d;
  logic [31:0] word_q, word_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [31:0] len_q, len_d;
  logic        in_msg_q, in_msg_d;
  logic [31:0] res_q, res_d;
  logic        out_valid_q, out_valid_d;

  logic [31:0] new_word;
  logic [31:0] mul_a, mul_b, prod;
  logic [31:0] fin_t, mix_r, hx13;

  assign new_word = word_q | ({24'd0, data_byte_i} << {cnt_q, 3'b000});
  assign fin_t    = hash_q ^ k_q ^ len_q;
  assign mix_r    = {hash_q[18:0] ^ k_q[18:0], hash_q[31:19] ^ k_q[31:19]};
  assign hx13     = hash_q ^ (hash_q >> 13);

  always_comb begin
    case (cmd_i.op)
      mm3_pkg::OP_SCR1: begin
        mul_a = k_q;
        mul_b = mm3_pkg::C1;
      end
      mm3_pkg::OP_SCR2: begin
        mul_a = {k_q[16:0], k_q[31:17]};
        mul_b = mm3_pkg::C2;
      end
      mm3_pkg::OP_FIN1: begin
        mul_a = fin_t ^ (fin_t >> 16);
        mul_b = mm3_pkg::F1;
      end
      mm3_pkg::OP_FIN2: begin
        mul_a = hx13;
        mul_b = mm3_pkg::F2;
      end
      default: begin
        mul_a = k_q;
        mul_b = mm3_pkg::C1;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    seed_d      = cfg_we_i ? cfg_data_i : seed_q;
    hash_d      = hash_q;
    k_d         = k_q;
    word_d      = word_q;
    cnt_d       = cnt_q;
    len_d       = len_q;
    in_msg_d    = in_msg_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (cmd_i.op)
      mm3_pkg::OP_ABSORB: begin
        if ((byte_present_i || last_i) && !in_msg_q) begin
          hash_d   = seed_q;
          in_msg_d = 1'b1;
        end
        if (byte_present_i) begin
          len_d = len_q + 32'd1;
          if (cnt_q == 2'd3) begin
            k_d    = new_word;
            word_d = '0;
            cnt_d  = '0;
          end else begin
            word_d = new_word;
            cnt_d  = cnt_q + 2'd1;
            if (last_i) k_d = new_word;
          end
        end else if (last_i) begin
          k_d = word_q;
        end
      end
      mm3_pkg::OP_SCR1: k_d = prod;
      mm3_pkg::OP_SCR2: k_d = prod;
      mm3_pkg::OP_MIX: begin
        hash_d = {mix_r[29:0], 2'b00} + mix_r + mm3_pkg::MixAdd;
        k_d    = '0;
      end
      mm3_pkg::OP_FIN1: hash_d = prod;
      mm3_pkg::OP_FIN2: hash_d = prod;
      mm3_pkg::OP_FIN3: begin
        res_d       = hash_q ^ (hash_q >> 16);
        out_valid_d = 1'b1;
        in_msg_d    = 1'b0;
        word_d      = '0;
        cnt_d       = '0;
        len_d       = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q      <= '0;
      word_q      <= '0;
      cnt_q       <= '0;
      len_q       <= '0;
      in_msg_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      seed_q      <= seed_d;
      word_q      <= word_d;
      cnt_q       <= cnt_d;
      len_q       <= len_d;
      in_msg_q    <= in_msg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hash_q <= hash_d;
    k_q    <= k_d;
    res_q  <= res_d;
  end

  assign sts_o.cnt_full = (cnt_q == 2'd3);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign hash_value_o   = res_q;

endmodule

// ----- hw/rtl/mm3_ctrl.sv -----
// Controller: sequences absorb, block mixing and finalisation steps.
module mm3_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          byte_present_i,
  input  logic          last_i,
  output logic          in_stall_o,
  input  mm3_pkg::sts_t sts_i,
  output mm3_pkg::cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCR1 = 3'd1;
  localparam logic [2:0] ST_SCR2 = 3'd2;
  localparam logic [2:0] ST_MIX  = 3'd3;
  localparam logic [2:0] ST_FIN1 = 3'd4;
  localparam logic [2:0] ST_FIN2 = 3'd5;
  localparam logic [2:0] ST_FIN3 = 3'd6;

  logic [2:0] state_q, state_d;
  logic       blk_q, blk_d;
  logic       pend_last_q, pend_last_d;
  logic       accept;

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d     = state_q;
    blk_d       = blk_q;
    pend_last_d = pend_last_q;
    cmd_o.op    = mm3_pkg::OP_NONE;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = mm3_pkg::OP_ABSORB;
          if (byte_present_i && sts_i.cnt_full) begin
            state_d     = ST_SCR1;
            blk_d       = 1'b1;
            pend_last_d = last_i;
          end else if (last_i) begin
            state_d     = ST_SCR1;
            blk_d       = 1'b0;
            pend_last_d = 1'b1;
          end
        end
      end
      ST_SCR1: begin
        cmd_o.op = mm3_pkg::OP_SCR1;
        state_d  = ST_SCR2;
      end
      ST_SCR2: begin
        cmd_o.op = mm3_pkg::OP_SCR2;
        state_d  = blk_q ? ST_MIX : ST_FIN1;
      end
      ST_MIX: begin
        cmd_o.op = mm3_pkg::OP_MIX;
        state_d  = pend_last_q ? ST_FIN1 : ST_IDLE;
      end
      ST_FIN1: begin
        cmd_o.op = mm3_pkg::OP_FIN1;
        state_d  = ST_FIN2;
      end
      ST_FIN2: begin
        cmd_o.op = mm3_pkg::OP_FIN2;
        state_d  = ST_FIN3;
      end
      ST_FIN3: begin
        if (sts_i.out_free) begin
          cmd_o.op = mm3_pkg::OP_FIN3;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      blk_q       <= 1'b0;
      pend_last_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      blk_q       <= blk_d;
      pend_last_q <= pend_last_d;
    end
  end

  a_fin_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN3 && !sts_i.out_free) |=> (state_q == ST_FIN3))
    else $error("finalisation left without a free result slot");

  a_blk_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && byte_present_i && sts_i.cnt_full) |=> (state_q == ST_SCR1 && blk_q))
    else $error("completed block not mixed");

  a_mix_return: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MIX && !pend_last_q) |=> (state_q == ST_IDLE))
    else $error("block mix did not return to idle");

  a_last_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last_i) |=> pend_last_q)
    else $error("last beat not flagged for finalisation");

endmodule

// ----- hw/rtl/murmur3_32_stream_hash.sv -----
// Top level of the streaming MurmurHash3 x86_32 hasher.
// Hashes a byte message arriving one byte per beat with the seed register as the
// initial value; the beat flagged last yields one 32-bit hash. A byte that does
// not complete a 4-byte block is absorbed in the idle state; a byte that completes
// a block is followed by two scramble multiplies and the mix, with the input stalled.
// A last beat adds two scramble multiplies, two avalanche multiplies and the result
// write, after the mix when it also completes a block. The steps take turns on the
// single shared 32x32 multiplier. The result sits in an output register, so a new
// message can be accepted while it waits to be taken.
module murmur3_32_stream_hash (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_present_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] hash_value_o
);

  mm3_pkg::cmd_t cmd;
  mm3_pkg::sts_t sts;

  mm3_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .byte_present_i (byte_present_i),
    .last_i         (last_i),
    .in_stall_o     (in_stall_o),
    .sts_i          (sts),
    .cmd_o          (cmd)
  );

  mm3_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .data_byte_i    (data_byte_i),
    .byte_present_i (byte_present_i),
    .last_i         (last_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .hash_value_o   (hash_value_o)
  );

endmodule

// ----- test/mm3_tb_pkg.sv -----
// Hash predictor and expected-result store for the MurmurHash3 stream hasher bench.
package mm3_tb_pkg;

  function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned r);
    return (v << r) | (v >> (32 - r));
  endfunction

  function automatic logic [31:0] scramble_word(input logic [31:0] k);
    logic [31:0] t;
    t = k * mm3_pkg::C1;
    t = rotl32(t, 15);
    t = t * mm3_pkg::C2;
    return t;
  endfunction

  function automatic logic [31:0] avalanche(input logic [31:0] h);
    logic [31:0] t;
    t = h ^ (h >> 16);
    t = t * mm3_pkg::F1;
    t = t ^ (t >> 13);
    t = t * mm3_pkg::F2;
    t = t ^ (t >> 16);
    return t;
  endfunction

  class hash_scoreboard;
    logic [31:0] seed_reg = '0;
    logic [31:0] run_hash = '0;
    logic [31:0] tail_word = '0;
    int unsigned tail_bytes = 0;
    logic [31:0] msg_len = '0;
    bit msg_open = 1'b0;
    logic [31:0] expected_hashes[$];
    int unsigned errors = 0;

    function void set_seed(input logic [31:0] v);
      seed_reg = v;
    endfunction

    function void predict_beat(input logic [7:0] b, input logic present, input logic last_flag);
      logic [31:0] h;
      if (!present && !last_flag) return;
      if (!msg_open) begin
        run_hash = seed_reg;
        tail_word = '0;
        tail_bytes = 0;
        msg_len = '0;
        msg_open = 1'b1;
      end
      if (present) begin
        tail_word = tail_word | (32'(b) << (8 * tail_bytes));
        tail_bytes++;
        msg_len = msg_len + 32'd1;
        if (tail_bytes == 4) begin
          run_hash = rotl32(run_hash ^ scramble_word(tail_word), 13);
          run_hash = run_hash * 32'd5 + mm3_pkg::MixAdd;
          tail_word = '0;
          tail_bytes = 0;
        end
      end
      if (!last_flag) return;
      h = run_hash;
      if (tail_bytes != 0) h = h ^ scramble_word(tail_word);
      h = avalanche(h ^ msg_len);
      expected_hashes.push_back(h);
      run_hash = '0;
      tail_word = '0;
      tail_bytes = 0;
      msg_len = '0;
      msg_open = 1'b0;
    endfunction

    function void check_hash(input logic [31:0] got);
      logic [31:0] want;
      if (expected_hashes.size() == 0) begin
        $error("hash_value: expected none, actual %h", got);
        errors++;
        return;
      end
      want = expected_hashes.pop_front();
      if (got !== want) begin
        $error("hash_value: expected %h, actual %h", want, got);
        errors++;
      end
    endfunction

    function int pending();
      return expected_hashes.size();
    endfunction
  endclass

endpackage

// ----- test/tb.sv -----
// Top-level bench for the MurmurHash3 stream hasher: stimulus, handshakes and watchdog.
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IdlePct    = 33;
  localparam int unsigned QuietLo    = 700;
  localparam int unsigned QuietHi    = 1050;
  localparam int unsigned HoldAt     = 300;
  localparam int unsigned HoldLen    = 300;
  localparam int unsigned Settle     = 12;
  localparam int unsigned StuckLimit = 2000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = '0;
  logic        byte_present = 1'b0;
  logic        last_flag = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] hash_value;

  mm3_tb_pkg::hash_scoreboard sb = new;
  int unsigned in_beats = 0;
  int unsigned sent = 0;
  int unsigned stuck = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  murmur3_32_stream_hash u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .data_byte_i   (data_byte),
    .byte_present_i(byte_present),
    .last_i        (last_flag),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .hash_value_o  (hash_value)
  );

  always #6 clk = ~clk;

  function automatic bit quiet();
    return (in_beats >= QuietLo) && (in_beats < QuietHi);
  endfunction

  always @(posedge clk) begin
    bit moved;
    moved = 1'b0;
    if (rst_n) begin
      if (cfg_we) begin
        sb.set_seed(cfg_data);
        moved = 1'b1;
      end
      if (in_valid && in_stall === 1'b0) begin
        sb.predict_beat(data_byte, byte_present, last_flag);
        in_beats++;
        moved = 1'b1;
      end
      if (out_valid === 1'b1 && !out_stall) begin
        sb.check_hash(hash_value);
        moved = 1'b1;
      end
      stuck = moved ? 0 : stuck + 1;
      if (stuck >= StuckLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // receiver: random stalls, one long hold-off so the block backs up
  always @(negedge clk) begin
    if (!hold_done && in_beats >= HoldAt) begin
      hold_done = 1'b1;
      hold_left = HoldLen;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet() && ($urandom_range(99) < IdlePct);
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic p, input logic l);
    while (!quiet() && $urandom_range(99) < IdlePct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    byte_present <= p;
    last_flag <= l;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (p || l) sent++;
    @(negedge clk);
  endtask

  task automatic send_message(input int unsigned len, input bit close_empty);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(19) == 0) send_beat(8'($urandom), 1'b0, 1'b0);
      send_beat(8'($urandom), 1'b1, (i == len - 1) && !close_empty);
    end
    if (len == 0 || close_empty) send_beat(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (Settle) @(negedge clk);
  endtask

  task automatic write_seed(input logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(input logic [31:0] seed_val, input int unsigned beats);
    int unsigned goal;
    int unsigned r;
    int unsigned len;
    goal = sent + beats;
    drain();
    write_seed(seed_val);
    while (sent < goal) begin
      r = $urandom_range(99);
      if (r < 10) len = 0;
      else if (r < 75) len = $urandom_range(8, 1);
      else if (r < 95) len = $urandom_range(20, 9);
      else len = $urandom_range(64, 21);
      send_message(len, $urandom_range(3) == 0);
    end
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty message on the reset seed, then an idle beat before another
    send_beat(8'h5a, 1'b0, 1'b1);
    send_beat(8'h00, 1'b0, 1'b0);
    send_beat(8'hff, 1'b0, 1'b1);

    drain();
    write_seed(32'hffffffff);
    send_beat(8'h00, 1'b1, 1'b1);
    send_beat(8'hff, 1'b1, 1'b0);
    send_beat(8'ha5, 1'b1, 1'b1);
    send_beat(8'h01, 1'b1, 1'b0);
    send_beat(8'h80, 1'b1, 1'b0);
    send_beat(8'hfe, 1'b1, 1'b1);
    send_beat(8'hff, 1'b1, 1'b0);
    send_beat(8'hff, 1'b1, 1'b0);
    send_beat(8'hff, 1'b1, 1'b0);
    send_beat(8'h7f, 1'b1, 1'b1);
    // full block closed by an empty beat, idle beat in between
    send_beat(8'h12, 1'b1, 1'b0);
    send_beat(8'h34, 1'b1, 1'b0);
    send_beat(8'hc3, 1'b0, 1'b0);
    send_beat(8'h56, 1'b1, 1'b0);
    send_beat(8'h78, 1'b1, 1'b0);
    send_beat(8'h9a, 1'b0, 1'b1);

    // seed changed mid-message: applies from the next message
    send_beat(8'hde, 1'b1, 1'b0);
    send_beat(8'had, 1'b1, 1'b0);
    drain();
    write_seed(32'h00000000);
    send_beat(8'hbe, 1'b1, 1'b0);
    send_beat(8'hef, 1'b1, 1'b0);
    send_beat(8'h01, 1'b1, 1'b1);
    send_beat(8'h42, 1'b1, 1'b1);

    random_phase($urandom, 450);
    random_phase(32'h00000000, 400);
    random_phase(32'hffffffff, 400);
    random_phase($urandom, 450);
    drain();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/mm3_pkg.sv
hw/rtl/mm3_datapath.sv
hw/rtl/mm3_ctrl.sv
hw/rtl/murmur3_32_stream_hash.sv
test/mm3_tb_pkg.sv
test/tb.sv
